// File: src/bivec_pkg.sv
// ----------------------------------------------------------------------------
// bivec_pkg
// Shared codes, widths, cell control type and read tree sizing functions
// for the bounded integer vector.
// ----------------------------------------------------------------------------
package bivec_pkg;

   localparam int DATA_W           = 32;
   localparam int CMD_W            = 4;
   localparam int POS_W            = 9;
   localparam int COUNT_W          = 9;
   localparam int STATUS_W         = 2;
   localparam int REQ_TDATA_W      = 48;
   localparam int RSP_TDATA_W      = 48;
   localparam int DEFAULT_CAPACITY = 256;

   // fan-in of one read tree node
   localparam int FAN = 16;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND = 4'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 4'd2;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_FIRST  = 4'd6;
   localparam logic [CMD_W-1:0] CMD_LAST   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd8;
   localparam logic [CMD_W-1:0] CMD_RESIZE = 4'd9;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // cell operations
   localparam int CELL_OP_W = 3;
   localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 3'd0;
   localparam logic [CELL_OP_W-1:0] CELL_WRITE  = 3'd1;
   localparam logic [CELL_OP_W-1:0] CELL_INSERT = 3'd2;
   localparam logic [CELL_OP_W-1:0] CELL_ERASE  = 3'd3;
   localparam logic [CELL_OP_W-1:0] CELL_FILL   = 3'd4;

   typedef struct packed {
      logic [CELL_OP_W-1:0] op;
      logic [DATA_W-1:0]    operand;
   } bivec_cell_ctl_type;

   // number of nodes on one tree level, level 0 being next to the leaves
   function automatic int tree_nodes(input int leaves, input int level);
      int m;
      m = leaves;
      for (int i = 0; i <= level; i++) begin
         m = (m + FAN - 1) / FAN;
      end
      return m;
   endfunction

   // number of registered levels down to a single root
   function automatic int tree_levels(input int leaves);
      int m;
      int lv;
      m  = (leaves + FAN - 1) / FAN;
      lv = 1;
      while (m > 1) begin
         m  = (m + FAN - 1) / FAN;
         lv = lv + 1;
      end
      return lv;
   endfunction

endpackage

// File: src/bounded_int_vector.sv
// ----------------------------------------------------------------------------
// bounded_int_vector
// Fixed-capacity vector of signed 32-bit integers with append, remove,
// insert, erase, read, write, first, last, clear and resize with fill.
//
//   channel   dir   ports                     payload (lowest bit up)
//   request   in    req_tvalid/tready/tdata   command, position, operand
//   response  out   rsp_tvalid/tready/tdata   read_value, element_count, status
//
// Every element is a cell in a row; each command updates all cells in the
// cycle it is transferred. Read, first and last gather the element through
// a registered OR tree of fan-in 16: the read address, then each tree level,
// is registered before the response loads.
// Reset clears the count and the handshake state; element values are not
// cleared. A request is taken only when the response register is empty or
// is being emptied in the same cycle, and no read is in flight.
// ----------------------------------------------------------------------------
module bounded_int_vector import bivec_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // command [3:0], position [12:4], operand [44:13], zero [47:45]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_value [31:0], element_count [40:32], status [42:41], zero [47:43]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int LEVELS = tree_levels(CAPACITY);
   localparam int TOK_W  = LEVELS + 1;
   localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);

   logic [CMD_W-1:0]  req_command;
   logic [POS_W-1:0]  req_position;
   logic [DATA_W-1:0] req_operand;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [TOK_W-1:0]    tok_ff;
   logic [TOK_W-1:0]    tok_in;
   logic [TOK_W:0]      tok_shift;
   logic [CMP_W-1:0]    raddr_ff;
   logic [CMP_W-1:0]    raddr_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [DATA_W-1:0]   rsp_value_ff;
   logic [DATA_W-1:0]   rsp_value_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [COUNT_W-1:0]  rsp_count_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;

   logic               accept;
   logic               busy;
   logic               done;
   logic [CMP_W-1:0]   cnt_x;
   logic [CMP_W-1:0]   pos_x;
   logic [CMP_W-1:0]   cnt_new;
   logic [CMP_W-1:0]   cell_pos;
   logic [CMP_W-1:0]   rd_addr;
   logic               rd_go;
   logic [STATUS_W-1:0] status;
   bivec_cell_ctl_type dec_ctl;
   bivec_cell_ctl_type cell_ctl;

   logic [DATA_W-1:0] cell_val [CAPACITY];
   logic [DATA_W-1:0] cell_rd  [CAPACITY];
   logic [DATA_W-1:0] tree_root;

   assign req_command  = req_tdata[CMD_W-1:0];
   assign req_position = req_tdata[CMD_W+POS_W-1:CMD_W];
   assign req_operand  = req_tdata[CMD_W+POS_W+DATA_W-1:CMD_W+POS_W];

   assign busy       = |tok_ff;
   assign done       = tok_ff[TOK_W-1];
   assign req_tready = !busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign cnt_x = {{(CMP_W-CNT_W){1'b0}}, count_ff};
   assign pos_x = {{(CMP_W-POS_W){1'b0}}, req_position};

   // command decode against the current count
   always_comb begin
      dec_ctl.op      = CELL_HOLD;
      dec_ctl.operand = req_operand;
      cnt_new         = cnt_x;
      cell_pos        = pos_x;
      rd_addr         = pos_x;
      rd_go           = 1'b0;
      status          = ST_OK;
      case (req_command)
         CMD_APPEND: begin
            if (cnt_x >= CAP_X) begin
               status = ST_FULL;
            end else begin
               dec_ctl.op = CELL_WRITE;
               cell_pos   = cnt_x;
               cnt_new    = cnt_x + 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (cnt_x == '0) status = ST_EMPTY;
            else cnt_new = cnt_x - 1'b1;
         end
         CMD_INSERT: begin
            if (pos_x > cnt_x) begin
               status = ST_RANGE;
            end else if (cnt_x >= CAP_X) begin
               status = ST_FULL;
            end else begin
               dec_ctl.op = CELL_INSERT;
               cnt_new    = cnt_x + 1'b1;
            end
         end
         CMD_ERASE: begin
            if (pos_x >= cnt_x) begin
               status = ST_RANGE;
            end else begin
               dec_ctl.op = CELL_ERASE;
               cnt_new    = cnt_x - 1'b1;
            end
         end
         CMD_READ: begin
            if (pos_x >= cnt_x) status = ST_RANGE;
            else rd_go = 1'b1;
         end
         CMD_WRITE: begin
            if (pos_x >= cnt_x) status = ST_RANGE;
            else dec_ctl.op = CELL_WRITE;
         end
         CMD_FIRST: begin
            if (cnt_x == '0) begin
               status = ST_EMPTY;
            end else begin
               rd_go   = 1'b1;
               rd_addr = '0;
            end
         end
         CMD_LAST: begin
            if (cnt_x == '0) begin
               status = ST_EMPTY;
            end else begin
               rd_go   = 1'b1;
               rd_addr = cnt_x - 1'b1;
            end
         end
         CMD_CLEAR: begin
            cnt_new = '0;
         end
         CMD_RESIZE: begin
            if (pos_x > CAP_X) begin
               status = ST_FULL;
            end else begin
               dec_ctl.op = CELL_FILL;
               cnt_new    = pos_x;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   always_comb begin
      cell_ctl    = dec_ctl;
      if (!accept) cell_ctl.op = CELL_HOLD;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_val;
      logic [DATA_W-1:0] right_val;

      if (i == 0) begin : g_first
         assign left_val = '0;
      end else begin : g_mid_l
         assign left_val = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_val = cell_val[i];
      end else begin : g_mid_r
         assign right_val = cell_val[i+1];
      end

      bivec_cell #(
         .IDX_W (CMP_W),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .pos       (cell_pos),
         .lim       (cnt_x),
         .raddr     (raddr_ff),
         .left_val  (left_val),
         .right_val (right_val),
         .val       (cell_val[i]),
         .rd_val    (cell_rd[i])
      );
   end

   bivec_or_tree #(
      .LEAVES (CAPACITY)
   ) u_tree (
      .clock (clock),
      .leaf  (cell_rd),
      .root  (tree_root)
   );

   // a token walks alongside the tree so the response loads once the root settles
   assign tok_shift = {tok_ff, accept && rd_go};
   assign tok_in    = tok_shift[TOK_W-1:0];
   assign raddr_in  = (accept && rd_go) ? rd_addr : raddr_ff;
   assign count_in  = accept ? cnt_new[CNT_W-1:0] : count_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = tree_root;
         rsp_count_in  = cnt_x[COUNT_W-1:0];
         rsp_status_in = ST_OK;
      end else if (accept && !rd_go) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_count_in  = cnt_new[COUNT_W-1:0];
         rsp_status_in = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         tok_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         tok_ff       <= tok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff      <= raddr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-DATA_W-COUNT_W-STATUS_W){1'b0}},
                        rsp_status_ff, rsp_count_ff, rsp_value_ff};

endmodule

// File: src/bivec_cell.sv
// ----------------------------------------------------------------------------
// bivec_cell
// One element of the vector: holds a value, takes its left or right
// neighbor on insert and erase, and offers its value to the read tree.
// ----------------------------------------------------------------------------
module bivec_cell import bivec_pkg::*; #(
   parameter int IDX_W = 10,
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  bivec_cell_ctl_type ctl,
   input  logic [IDX_W-1:0]   pos,
   input  logic [IDX_W-1:0]   lim,
   input  logic [IDX_W-1:0]   raddr,
   input  logic [DATA_W-1:0]  left_val,
   input  logic [DATA_W-1:0]  right_val,
   output logic [DATA_W-1:0]  val,
   output logic [DATA_W-1:0]  rd_val
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_W-1:0] val_ff;
   logic [DATA_W-1:0] val_in;

   always_comb begin
      val_in = val_ff;
      case (ctl.op)
         CELL_WRITE: begin
            if (MY_IDX == pos) val_in = ctl.operand;
         end
         CELL_INSERT: begin
            if (MY_IDX == pos) val_in = ctl.operand;
            else if (MY_IDX > pos) val_in = left_val;
         end
         CELL_ERASE: begin
            if (MY_IDX >= pos) val_in = right_val;
         end
         CELL_FILL: begin
            if (MY_IDX >= lim && MY_IDX < pos) val_in = ctl.operand;
         end
         default: val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val    = val_ff;
   assign rd_val = (raddr == MY_IDX) ? val_ff : '0;

endmodule

// File: src/bivec_or_tree.sv
// ----------------------------------------------------------------------------
// bivec_or_tree
// Registered OR tree that gathers the one selected cell value (all other
// leaves are zero) down to a single root, one level per cycle.
// ----------------------------------------------------------------------------
module bivec_or_tree import bivec_pkg::*; #(
   parameter int LEAVES = DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic [DATA_W-1:0] leaf [LEAVES],
   output logic [DATA_W-1:0] root
);

   localparam int LEVELS = tree_levels(LEAVES);
   localparam int MAXN   = tree_nodes(LEAVES, 0);

   logic [DATA_W-1:0] node_ff [LEVELS][MAXN];

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar j = 0; j < MAXN; j++) begin : g_node
         logic [DATA_W-1:0] part [FAN];
         logic [DATA_W-1:0] node_in;

         for (genvar k = 0; k < FAN; k++) begin : g_in
            localparam int SRC = j * FAN + k;
            if (l == 0 && SRC < LEAVES) begin : g_leaf
               assign part[k] = leaf[SRC];
            end else if (l > 0 && SRC < tree_nodes(LEAVES, l - 1)) begin : g_inner
               assign part[k] = node_ff[l-1][SRC];
            end else begin : g_zero
               assign part[k] = '0;
            end
         end

         always_comb begin
            node_in = '0;
            for (int k = 0; k < FAN; k++) begin
               node_in = node_in | part[k];
            end
         end

         always_ff @(posedge clock) begin
            node_ff[l][j] <= node_in;
         end
      end
   end

   assign root = node_ff[LEVELS-1][0];

endmodule
